>>> rtl/ddf_pkg.sv
// Shared types, constants and helper functions for the decimal display formatter.
// Depends on nothing; every other file of the block refers to it by scoped names.
package ddf_pkg;

    // Field widths of the two channels.
    localparam int OpBits    = 4;
    localparam int ValueBits = 18;
    localparam int CharBits  = 7;
    localparam int LenBits   = 3;
    localparam int NumChars  = 7;

    // Magnitude after saturation and its decimal form.
    localparam int MagBits   = 17;
    localparam int BcdDigits = 5;
    localparam int BcdBits   = 4 * BcdDigits;
    localparam logic [MagBits-1:0] MagLimit = MagBits'(99999);

    // Double-dabble steps done in each of the three conversion stages.
    localparam int StepsA = 6;
    localparam int StepsB = 6;
    localparam int StepsC = MagBits - StepsA - StepsB;

    // ASCII codes used in the layouts.
    localparam logic [CharBits-1:0] ChZero  = 7'h30;
    localparam logic [CharBits-1:0] ChPlus  = 7'h2B;
    localparam logic [CharBits-1:0] ChMinus = 7'h2D;
    localparam logic [CharBits-1:0] ChPoint = 7'h2E;
    localparam logic [CharBits-1:0] ChSpace = 7'h20;
    localparam logic [CharBits-1:0] ChNull  = 7'h00;

    // Layout selector codes.
    typedef enum logic [OpBits-1:0] {
        OP_TWO_DIGIT   = 4'd0,
        OP_THREE_RIGHT = 4'd1,
        OP_THREE_LEFT  = 4'd2,
        OP_FOUR_RIGHT  = 4'd3,
        OP_FIVE_RIGHT  = 4'd4,
        OP_SIGN_3_1    = 4'd5,
        OP_DIGIT_2_2   = 4'd6,
        OP_SIGN_4_1    = 4'd7,
        OP_SIGN_3_2    = 4'd8
    } ddf_op_t;

    // Word carried down the conversion pipeline.
    typedef struct packed {
        logic [OpBits-1:0]  op;
        logic               neg;
        logic [BcdBits-1:0] bcd;
        logic [MagBits-1:0] rest;
    } ddf_work_t;

    // One double-dabble step: correct each digit, then shift in the next binary bit.
    function automatic ddf_work_t dabble_shift(ddf_work_t w);
        ddf_work_t          r;
        logic [BcdBits-1:0] b;
        r = w;
        b = w.bcd;
        for (int k = 0; k < BcdDigits; k++) begin
            if (b[4*k +: 4] >= 4'd5) begin
                b[4*k +: 4] = b[4*k +: 4] + 4'd3;
            end
        end
        r.bcd  = {b[BcdBits-2:0], w.rest[MagBits-1]};
        r.rest = {w.rest[MagBits-2:0], 1'b0};
        return r;
    endfunction

    // ASCII character of one decimal digit.
    function automatic logic [CharBits-1:0] ascii_digit(logic [3:0] d);
        return ChZero + {3'b000, d};
    endfunction

endpackage

>>> rtl/ddf_magnitude.sv
// First pipeline stage: sign, absolute value and saturation of the input word.
// Depends on ddf_pkg for widths, the saturation limit and the work type.
module ddf_magnitude (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ddf_pkg::OpBits-1:0]         operation,
    input  logic signed [ddf_pkg::ValueBits-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ddf_pkg::ddf_work_t                 out_word
);

    logic                               valid_reg;
    ddf_pkg::ddf_work_t                 word_reg;
    ddf_pkg::ddf_work_t                 word_next;
    logic [ddf_pkg::ValueBits-1:0]      raw;
    logic [ddf_pkg::ValueBits-1:0]      abs_val;
    logic                               load;

    // The stage takes a new word when empty or when its word moves on.
    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // Absolute value, clipped to the largest five-digit number.
    always_comb begin
        raw     = $unsigned(value);
        abs_val = raw[ddf_pkg::ValueBits-1] ? (ddf_pkg::ValueBits'(0) - raw) : raw;
        word_next.op   = operation;
        word_next.neg  = raw[ddf_pkg::ValueBits-1];
        word_next.bcd  = '0;
        if (abs_val > {1'b0, ddf_pkg::MagLimit}) begin
            word_next.rest = ddf_pkg::MagLimit;
        end else begin
            word_next.rest = abs_val[ddf_pkg::MagBits-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> rtl/ddf_dabble.sv
// Binary to BCD conversion by double dabble, spread over three register stages.
// Depends on ddf_pkg for the work type, the step counts and the shift function.
module ddf_dabble (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  ddf_pkg::ddf_work_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output ddf_pkg::ddf_work_t out_word
);

    logic               a_valid_reg;
    logic               b_valid_reg;
    logic               c_valid_reg;
    ddf_pkg::ddf_work_t a_word_reg;
    ddf_pkg::ddf_work_t b_word_reg;
    ddf_pkg::ddf_work_t c_word_reg;
    ddf_pkg::ddf_work_t a_word_next;
    ddf_pkg::ddf_work_t b_word_next;
    ddf_pkg::ddf_work_t c_word_next;
    logic               a_load;
    logic               b_load;
    logic               c_load;

    // Each stage moves when empty or when the stage after it can take its word.
    assign c_load   = !c_valid_reg || out_ready;
    assign b_load   = !b_valid_reg || c_load;
    assign a_load   = !a_valid_reg || b_load;
    assign in_ready = a_load;

    // Most significant binary bits first.
    always_comb begin
        a_word_next = in_word;
        for (int i = 0; i < ddf_pkg::StepsA; i++) begin
            a_word_next = ddf_pkg::dabble_shift(a_word_next);
        end
    end

    // Middle group of bits.
    always_comb begin
        b_word_next = a_word_reg;
        for (int i = 0; i < ddf_pkg::StepsB; i++) begin
            b_word_next = ddf_pkg::dabble_shift(b_word_next);
        end
    end

    // Least significant bits; the BCD value is then complete.
    always_comb begin
        c_word_next = b_word_reg;
        for (int i = 0; i < ddf_pkg::StepsC; i++) begin
            c_word_next = ddf_pkg::dabble_shift(c_word_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_load) begin
                a_valid_reg <= in_valid;
            end
            if (b_load) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_load) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load && in_valid) begin
            a_word_reg <= a_word_next;
        end
        if (b_load && a_valid_reg) begin
            b_word_reg <= b_word_next;
        end
        if (c_load && b_valid_reg) begin
            c_word_reg <= c_word_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_word  = c_word_reg;

endmodule

>>> rtl/ddf_format.sv
// Last pipeline stage: lays the decimal digits out as ASCII text and holds the result word.
// Depends on ddf_pkg for layout codes, character constants and the work type.
module ddf_format (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ddf_pkg::ddf_work_t                in_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ddf_pkg::CharBits-1:0]      chars [ddf_pkg::NumChars],
    output logic [ddf_pkg::LenBits-1:0]       text_length
);

    logic                           valid_reg;
    logic                           load;
    logic [ddf_pkg::CharBits-1:0]   chars_reg [ddf_pkg::NumChars];
    logic [ddf_pkg::CharBits-1:0]   chars_next [ddf_pkg::NumChars];
    logic [ddf_pkg::LenBits-1:0]    len_reg;
    logic [ddf_pkg::LenBits-1:0]    len_next;
    logic [3:0]                     d0;
    logic [3:0]                     d1;
    logic [3:0]                     d2;
    logic [3:0]                     d3;
    logic [3:0]                     d4;
    logic                           ge10;
    logic                           ge100;
    logic                           ge1000;
    logic                           ge10000;
    logic [ddf_pkg::CharBits-1:0]   sign_ch;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // Digits, and whether the magnitude reaches each power of ten.
    always_comb begin
        d0      = in_word.bcd[3:0];
        d1      = in_word.bcd[7:4];
        d2      = in_word.bcd[11:8];
        d3      = in_word.bcd[15:12];
        d4      = in_word.bcd[19:16];
        ge10000 = (d4 != 4'd0);
        ge1000  = ge10000 || (d3 != 4'd0);
        ge100   = ge1000 || (d2 != 4'd0);
        ge10    = ge100 || (d1 != 4'd0);
        sign_ch = in_word.neg ? ddf_pkg::ChMinus : ddf_pkg::ChPlus;
    end

    // Character layout for each selector; unused positions stay zero.
    always_comb begin
        for (int i = 0; i < ddf_pkg::NumChars; i++) begin
            chars_next[i] = ddf_pkg::ChNull;
        end
        len_next = 3'd0;
        case (in_word.op)
            ddf_pkg::OP_TWO_DIGIT: begin
                chars_next[0] = ddf_pkg::ascii_digit(d1);
                chars_next[1] = ddf_pkg::ascii_digit(d0);
                len_next      = 3'd2;
            end
            ddf_pkg::OP_THREE_RIGHT: begin
                chars_next[0] = ge100 ? ddf_pkg::ascii_digit(d2) : ddf_pkg::ChSpace;
                chars_next[1] = ge10 ? ddf_pkg::ascii_digit(d1) : ddf_pkg::ChSpace;
                chars_next[2] = ddf_pkg::ascii_digit(d0);
                len_next      = 3'd3;
            end
            ddf_pkg::OP_THREE_LEFT: begin
                if (ge100) begin
                    chars_next[0] = ddf_pkg::ascii_digit(d2);
                    chars_next[1] = ddf_pkg::ascii_digit(d1);
                    chars_next[2] = ddf_pkg::ascii_digit(d0);
                    len_next      = 3'd3;
                end else if (ge10) begin
                    chars_next[0] = ddf_pkg::ascii_digit(d1);
                    chars_next[1] = ddf_pkg::ascii_digit(d0);
                    len_next      = 3'd2;
                end else begin
                    chars_next[0] = ddf_pkg::ascii_digit(d0);
                    len_next      = 3'd1;
                end
            end
            ddf_pkg::OP_FOUR_RIGHT: begin
                chars_next[0] = ge1000 ? ddf_pkg::ascii_digit(d3) : ddf_pkg::ChSpace;
                chars_next[1] = ge100 ? ddf_pkg::ascii_digit(d2) : ddf_pkg::ChSpace;
                chars_next[2] = ge10 ? ddf_pkg::ascii_digit(d1) : ddf_pkg::ChSpace;
                chars_next[3] = ddf_pkg::ascii_digit(d0);
                len_next      = 3'd4;
            end
            ddf_pkg::OP_FIVE_RIGHT: begin
                chars_next[0] = ge10000 ? ddf_pkg::ascii_digit(d4) : ddf_pkg::ChSpace;
                chars_next[1] = ge1000 ? ddf_pkg::ascii_digit(d3) : ddf_pkg::ChSpace;
                chars_next[2] = ge100 ? ddf_pkg::ascii_digit(d2) : ddf_pkg::ChSpace;
                chars_next[3] = ge10 ? ddf_pkg::ascii_digit(d1) : ddf_pkg::ChSpace;
                chars_next[4] = ddf_pkg::ascii_digit(d0);
                len_next      = 3'd5;
            end
            ddf_pkg::OP_SIGN_3_1: begin
                chars_next[0] = sign_ch;
                chars_next[1] = ddf_pkg::ascii_digit(d3);
                chars_next[2] = ddf_pkg::ascii_digit(d2);
                chars_next[3] = ddf_pkg::ascii_digit(d1);
                chars_next[4] = ddf_pkg::ChPoint;
                chars_next[5] = ddf_pkg::ascii_digit(d0);
                len_next      = 3'd6;
            end
            ddf_pkg::OP_DIGIT_2_2: begin
                chars_next[0] = in_word.neg ? ddf_pkg::ChMinus : ddf_pkg::ascii_digit(d4);
                chars_next[1] = ddf_pkg::ascii_digit(d3);
                chars_next[2] = ddf_pkg::ascii_digit(d2);
                chars_next[3] = ddf_pkg::ChPoint;
                chars_next[4] = ddf_pkg::ascii_digit(d1);
                chars_next[5] = ddf_pkg::ascii_digit(d0);
                len_next      = 3'd6;
            end
            ddf_pkg::OP_SIGN_4_1: begin
                chars_next[0] = sign_ch;
                chars_next[1] = ddf_pkg::ascii_digit(d4);
                chars_next[2] = ddf_pkg::ascii_digit(d3);
                chars_next[3] = ddf_pkg::ascii_digit(d2);
                chars_next[4] = ddf_pkg::ascii_digit(d1);
                chars_next[5] = ddf_pkg::ChPoint;
                chars_next[6] = ddf_pkg::ascii_digit(d0);
                len_next      = 3'd7;
            end
            ddf_pkg::OP_SIGN_3_2: begin
                chars_next[0] = sign_ch;
                chars_next[1] = ddf_pkg::ascii_digit(d4);
                chars_next[2] = ddf_pkg::ascii_digit(d3);
                chars_next[3] = ddf_pkg::ascii_digit(d2);
                chars_next[4] = ddf_pkg::ChPoint;
                chars_next[5] = ddf_pkg::ascii_digit(d1);
                chars_next[6] = ddf_pkg::ascii_digit(d0);
                len_next      = 3'd7;
            end
            default: begin
                len_next = 3'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    // Output register: holds the word steady while the consumer stalls.
    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            chars_reg <= chars_next;
            len_reg   <= len_next;
        end
    end

    assign out_valid   = valid_reg;
    assign chars       = chars_reg;
    assign text_length = len_reg;

endmodule

>>> rtl/decimal_display_formatter_top.sv
// Top level of the decimal display formatter: magnitude, BCD conversion and layout stages.
// Depends on ddf_pkg, ddf_magnitude, ddf_dabble and ddf_format.
//
//   Channel  | Ports                                         | Direction
//   ---------+-----------------------------------------------+----------
//   input    | s_valid, s_ready, s_operation, s_value        | in
//   result   | m_valid, m_ready, m_char_0..m_char_6,         | out
//            | m_text_length                                 |
//
// One word is accepted per cycle while the result side does not stall; its result is offered
// after passing five registers: the magnitude stage (loaded at the accepting edge), three for
// the 17-step double-dabble conversion and one for layout.
// Reset (aresetn low at a clock edge) empties all five stages; the data registers keep
// whatever they held. A stall on the result side holds each full stage in place and backs
// up through s_ready, so no word is dropped or repeated; empty stages keep filling meanwhile.
module decimal_display_formatter_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ddf_pkg::OpBits-1:0]          s_operation,
    input  logic signed [ddf_pkg::ValueBits-1:0] s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ddf_pkg::CharBits-1:0]        m_char_0,
    output logic [ddf_pkg::CharBits-1:0]        m_char_1,
    output logic [ddf_pkg::CharBits-1:0]        m_char_2,
    output logic [ddf_pkg::CharBits-1:0]        m_char_3,
    output logic [ddf_pkg::CharBits-1:0]        m_char_4,
    output logic [ddf_pkg::CharBits-1:0]        m_char_5,
    output logic [ddf_pkg::CharBits-1:0]        m_char_6,
    output logic [ddf_pkg::LenBits-1:0]         m_text_length
);

    logic                           mag_valid;
    logic                           mag_ready;
    ddf_pkg::ddf_work_t             mag_word;
    logic                           bcd_valid;
    logic                           bcd_ready;
    ddf_pkg::ddf_work_t             bcd_word;
    logic [ddf_pkg::CharBits-1:0]   chars [ddf_pkg::NumChars];

    // Sign and saturated magnitude.
    ddf_magnitude u_magnitude (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .operation (s_operation),
        .value     (s_value),
        .out_valid (mag_valid),
        .out_ready (mag_ready),
        .out_word  (mag_word)
    );

    // Binary to BCD.
    ddf_dabble u_dabble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mag_valid),
        .in_ready  (mag_ready),
        .in_word   (mag_word),
        .out_valid (bcd_valid),
        .out_ready (bcd_ready),
        .out_word  (bcd_word)
    );

    // Text layout and result register.
    ddf_format u_format (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (bcd_valid),
        .in_ready    (bcd_ready),
        .in_word     (bcd_word),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .chars       (chars),
        .text_length (m_text_length)
    );

    assign m_char_0 = chars[0];
    assign m_char_1 = chars[1];
    assign m_char_2 = chars[2];
    assign m_char_3 = chars[3];
    assign m_char_4 = chars[4];
    assign m_char_5 = chars[5];
    assign m_char_6 = chars[6];

endmodule

>>> rtl/ddf_checker.sv
// Port-level checks on the decimal display formatter, bound to its top level.
// Depends on ddf_pkg for character codes and widths.
module ddf_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [ddf_pkg::CharBits-1:0]        m_char_0,
    input logic [ddf_pkg::CharBits-1:0]        m_char_1,
    input logic [ddf_pkg::CharBits-1:0]        m_char_6,
    input logic [ddf_pkg::LenBits-1:0]         m_text_length
);

    // A stalled result word stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word withdrawn while stalled");

    // A stalled result word keeps its length and its first and last characters.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_text_length) && $stable(m_char_0)
            && $stable(m_char_6))
        else $error("result word changed while stalled");

    // An empty string has its first two positions cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_text_length == 3'd0 |-> m_char_0 == ddf_pkg::ChNull
            && m_char_1 == ddf_pkg::ChNull)
        else $error("characters present in empty text");

    // Seven-character layouts start with a sign.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_text_length == 3'd7 |-> m_char_0 == ddf_pkg::ChPlus
            || m_char_0 == ddf_pkg::ChMinus)
        else $error("seven-character text without sign");

    // Six-character layouts leave the last position cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_text_length == 3'd6 |-> m_char_6 == ddf_pkg::ChNull)
        else $error("character beyond text length");

endmodule

bind decimal_display_formatter_top ddf_checker u_ddf_checker (.*);

>>> sim/decimal_display_formatter_top_tb.sv
// Self-checking testbench for the decimal display formatter: directed and random words,
// random idling on both channels and two long result stalls. Depends on ddf_pkg and the RTL.
`timescale 1ns / 1ps

module decimal_display_formatter_top_tb;

    localparam int CycleLimit = 200000;
    localparam int HoldCycles = 150;
    localparam logic [ddf_pkg::OpBits-1:0] OpUnusedLo = ddf_pkg::OP_SIGN_3_2 + 4'd1;
    localparam logic [ddf_pkg::OpBits-1:0] OpCodeMax  = {ddf_pkg::OpBits{1'b1}};

    // One formatted string as it leaves the block.
    typedef struct packed {
        logic [ddf_pkg::NumChars-1:0][ddf_pkg::CharBits-1:0] chars;
        logic [ddf_pkg::LenBits-1:0]                         len;
    } display_text_t;

    // Predicts the string for every accepted word and checks results in order.
    class display_text_board;
        display_text_t expected_text[$];
        int            errors = 0;

        function logic [ddf_pkg::CharBits-1:0] digit_of(int unsigned mag, int unsigned div);
            return ddf_pkg::ChZero + ddf_pkg::CharBits'((mag / div) % 10);
        endfunction

        function logic [ddf_pkg::CharBits-1:0] padded(int unsigned mag, int unsigned div);
            return (mag >= div) ? digit_of(mag, div) : ddf_pkg::ChSpace;
        endfunction

        function display_text_t format_display(logic [ddf_pkg::OpBits-1:0] op,
                                               logic signed [ddf_pkg::ValueBits-1:0] val);
            display_text_t                t;
            int                           v;
            int unsigned                  mag;
            logic                         neg;
            logic [ddf_pkg::CharBits-1:0] sgn;
            t   = '0;
            v   = val;
            neg = (v < 0);
            mag = neg ? -v : v;
            if (mag > 99999) begin
                mag = 99999;
            end
            sgn = neg ? ddf_pkg::ChMinus : ddf_pkg::ChPlus;
            case (op)
                ddf_pkg::OP_TWO_DIGIT: begin
                    t.chars[0] = digit_of(mag, 10);
                    t.chars[1] = digit_of(mag, 1);
                    t.len = 3'd2;
                end
                ddf_pkg::OP_THREE_RIGHT: begin
                    t.chars[0] = padded(mag, 100);
                    t.chars[1] = padded(mag, 10);
                    t.chars[2] = digit_of(mag, 1);
                    t.len = 3'd3;
                end
                ddf_pkg::OP_THREE_LEFT: begin
                    // Left-aligned: the length follows the number of digits shown.
                    if (mag >= 100) begin
                        t.chars[0] = digit_of(mag, 100);
                        t.chars[1] = digit_of(mag, 10);
                        t.chars[2] = digit_of(mag, 1);
                        t.len = 3'd3;
                    end else if (mag >= 10) begin
                        t.chars[0] = digit_of(mag, 10);
                        t.chars[1] = digit_of(mag, 1);
                        t.len = 3'd2;
                    end else begin
                        t.chars[0] = digit_of(mag, 1);
                        t.len = 3'd1;
                    end
                end
                ddf_pkg::OP_FOUR_RIGHT: begin
                    t.chars[0] = padded(mag, 1000);
                    t.chars[1] = padded(mag, 100);
                    t.chars[2] = padded(mag, 10);
                    t.chars[3] = digit_of(mag, 1);
                    t.len = 3'd4;
                end
                ddf_pkg::OP_FIVE_RIGHT: begin
                    t.chars[0] = padded(mag, 10000);
                    t.chars[1] = padded(mag, 1000);
                    t.chars[2] = padded(mag, 100);
                    t.chars[3] = padded(mag, 10);
                    t.chars[4] = digit_of(mag, 1);
                    t.len = 3'd5;
                end
                ddf_pkg::OP_SIGN_3_1: begin
                    t.chars[0] = sgn;
                    t.chars[1] = digit_of(mag, 1000);
                    t.chars[2] = digit_of(mag, 100);
                    t.chars[3] = digit_of(mag, 10);
                    t.chars[4] = ddf_pkg::ChPoint;
                    t.chars[5] = digit_of(mag, 1);
                    t.len = 3'd6;
                end
                ddf_pkg::OP_DIGIT_2_2: begin
                    // The leading place carries the minus sign or the ten-thousands digit.
                    t.chars[0] = neg ? ddf_pkg::ChMinus : digit_of(mag, 10000);
                    t.chars[1] = digit_of(mag, 1000);
                    t.chars[2] = digit_of(mag, 100);
                    t.chars[3] = ddf_pkg::ChPoint;
                    t.chars[4] = digit_of(mag, 10);
                    t.chars[5] = digit_of(mag, 1);
                    t.len = 3'd6;
                end
                ddf_pkg::OP_SIGN_4_1: begin
                    t.chars[0] = sgn;
                    t.chars[1] = digit_of(mag, 10000);
                    t.chars[2] = digit_of(mag, 1000);
                    t.chars[3] = digit_of(mag, 100);
                    t.chars[4] = digit_of(mag, 10);
                    t.chars[5] = ddf_pkg::ChPoint;
                    t.chars[6] = digit_of(mag, 1);
                    t.len = 3'd7;
                end
                ddf_pkg::OP_SIGN_3_2: begin
                    t.chars[0] = sgn;
                    t.chars[1] = digit_of(mag, 10000);
                    t.chars[2] = digit_of(mag, 1000);
                    t.chars[3] = digit_of(mag, 100);
                    t.chars[4] = ddf_pkg::ChPoint;
                    t.chars[5] = digit_of(mag, 10);
                    t.chars[6] = digit_of(mag, 1);
                    t.len = 3'd7;
                end
                default: begin
                    // Unused selectors give an empty string.
                end
            endcase
            return t;
        endfunction

        function void note_word(logic [ddf_pkg::OpBits-1:0] op,
                                logic signed [ddf_pkg::ValueBits-1:0] val);
            expected_text.push_back(format_display(op, val));
        endfunction

        function void check_result(display_text_t got);
            display_text_t want;
            if (expected_text.size() == 0) begin
                $error("Result word arrived with no word outstanding");
                errors++;
                return;
            end
            want = expected_text.pop_front();
            for (int i = 0; i < ddf_pkg::NumChars; i++) begin
                if (got.chars[i] !== want.chars[i]) begin
                    $error("m_char_%0d: expected %h, got %h", i, want.chars[i], got.chars[i]);
                    errors++;
                end
            end
            if (got.len !== want.len) begin
                $error("m_text_length: expected %0d, got %0d", want.len, got.len);
                errors++;
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction

        function void report_leftovers();
            if (expected_text.size() != 0) begin
                $error("%0d result words never arrived", expected_text.size());
                errors++;
            end
        endfunction
    endclass

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic [ddf_pkg::OpBits-1:0]           s_operation = '0;
    logic signed [ddf_pkg::ValueBits-1:0] s_value = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic [ddf_pkg::CharBits-1:0]         m_char_0, m_char_1, m_char_2, m_char_3;
    logic [ddf_pkg::CharBits-1:0]         m_char_4, m_char_5, m_char_6;
    logic [ddf_pkg::LenBits-1:0]          m_text_length;

    display_text_board board = new();
    bit                calm = 1'b0;
    int                cycles = 0;

    decimal_display_formatter_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_0      (m_char_0),
        .m_char_1      (m_char_1),
        .m_char_2      (m_char_2),
        .m_char_3      (m_char_3),
        .m_char_4      (m_char_4),
        .m_char_5      (m_char_5),
        .m_char_6      (m_char_6),
        .m_text_length (m_text_length)
    );

    // Clock with an 8 ns period.
    always #4 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Every accepted result word goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result({m_char_6, m_char_5, m_char_4, m_char_3,
                                m_char_2, m_char_1, m_char_0, m_text_length});
        end
    end

    // Result side: random back-pressure, plus two long hold-offs that fill the pipeline.
    initial begin
        int rx_cycle;
        int hold_left;
        rx_cycle  = 0;
        hold_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (rx_cycle == 300 || rx_cycle == 2000) begin
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 30);
            end
        end
    end

    // Offers one word after a random gap and waits until it is taken.
    task automatic send_word(input logic [ddf_pkg::OpBits-1:0] op,
                             input logic signed [ddf_pkg::ValueBits-1:0] val);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 30) begin
            s_valid     <= 1'b0;
            s_operation <= ddf_pkg::OpBits'($urandom);
            s_value     <= ddf_pkg::ValueBits'($urandom);
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= val;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        board.note_word(op, val);
    endtask

    // Random value: mostly within the saturation limit, with small numbers and raw codes too.
    function automatic logic signed [ddf_pkg::ValueBits-1:0] random_value();
        int v;
        case ($urandom_range(9))
            0, 1:    v = $urandom_range(120);
            2:       v = -int'($urandom_range(120));
            3:       v = 99990 + $urandom_range(20);
            7, 8:    v = $urandom;
            default: v = int'($urandom_range(199998)) - 99999;
        endcase
        return ddf_pkg::ValueBits'(v);
    endfunction

    // Directed words: digit-count boundaries, saturation, negatives, zero and unused selectors.
    logic [ddf_pkg::OpBits-1:0] dir_op [24] = '{
        ddf_pkg::OP_TWO_DIGIT, ddf_pkg::OP_TWO_DIGIT,
        ddf_pkg::OP_THREE_RIGHT, ddf_pkg::OP_THREE_RIGHT,
        ddf_pkg::OP_THREE_LEFT, ddf_pkg::OP_THREE_LEFT, ddf_pkg::OP_THREE_LEFT,
        ddf_pkg::OP_THREE_LEFT, ddf_pkg::OP_THREE_LEFT,
        ddf_pkg::OP_FOUR_RIGHT, ddf_pkg::OP_FOUR_RIGHT,
        ddf_pkg::OP_FIVE_RIGHT, ddf_pkg::OP_FIVE_RIGHT,
        ddf_pkg::OP_SIGN_3_1, ddf_pkg::OP_SIGN_3_1,
        ddf_pkg::OP_DIGIT_2_2, ddf_pkg::OP_DIGIT_2_2, ddf_pkg::OP_DIGIT_2_2,
        ddf_pkg::OP_SIGN_4_1, ddf_pkg::OP_SIGN_4_1,
        ddf_pkg::OP_SIGN_3_2, ddf_pkg::OP_SIGN_3_2, OpUnusedLo, OpCodeMax
    };
    logic signed [ddf_pkg::ValueBits-1:0] dir_val [24] = '{
        7, -131072, 5, -42,
        0, 10, 99, 100, -123456,
        999, 131071, 9999, 99999,
        0, -1, 0, 54321, -99999,
        100000, -5, 12345, -131072, 1, -1
    };

    initial begin
        logic [ddf_pkg::OpBits-1:0]           op;
        logic signed [ddf_pkg::ValueBits-1:0] val;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 24; i++) begin
            send_word(dir_op[i], dir_val[i]);
        end

        // Random words; a stretch in the middle runs with no idling on either side.
        for (int n = 0; n < 1650; n++) begin
            calm = (n >= 200 && n < 600);
            if ($urandom_range(9) == 0) begin
                op = ddf_pkg::OpBits'($urandom_range(OpCodeMax, OpUnusedLo));
            end else begin
                op = ddf_pkg::OpBits'($urandom_range(ddf_pkg::OP_SIGN_3_2));
            end
            val = random_value();
            send_word(op, val);
        end
        calm = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain, then allow the pipeline depth again for any stray word.
        while (board.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        board.report_leftovers();

        if (board.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
